>>> rtl/indent_aware_lexer_unit_macros.svh
// ----------------------------------------------------------------------------
// Indentation lexer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef INDENT_AWARE_LEXER_UNIT_MACROS_SVH
`define INDENT_AWARE_LEXER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define IAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ial_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation lexer package
// Token codes, character codes, keyword table and shared types.
// ----------------------------------------------------------------------------
package ial_pkg;

  localparam int STACK_DEPTH_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int INDENT_BITS_DEF   = 8;
  localparam int OUT_FIFO_DEPTH    = 4;
  localparam int KW_COUNT          = 12;

  localparam logic [5:0] K_ERROR   = 6'd0;
  localparam logic [5:0] K_IF      = 6'd1;
  localparam logic [5:0] K_ID      = 6'd13;
  localparam logic [5:0] K_NUMBER  = 6'd14;
  localparam logic [5:0] K_STRING  = 6'd15;
  localparam logic [5:0] K_GT      = 6'd16;
  localparam logic [5:0] K_GE      = 6'd17;
  localparam logic [5:0] K_LT      = 6'd18;
  localparam logic [5:0] K_LE      = 6'd19;
  localparam logic [5:0] K_MINUS   = 6'd20;
  localparam logic [5:0] K_ARROW   = 6'd21;
  localparam logic [5:0] K_ASSIGN  = 6'd22;
  localparam logic [5:0] K_EQ      = 6'd23;
  localparam logic [5:0] K_NEQ     = 6'd24;
  localparam logic [5:0] K_PLUS    = 6'd25;
  localparam logic [5:0] K_MUL     = 6'd26;
  localparam logic [5:0] K_DIV     = 6'd27;
  localparam logic [5:0] K_MOD     = 6'd28;
  localparam logic [5:0] K_LPAR    = 6'd29;
  localparam logic [5:0] K_RPAR    = 6'd30;
  localparam logic [5:0] K_LBR     = 6'd31;
  localparam logic [5:0] K_RBR     = 6'd32;
  localparam logic [5:0] K_COMMA   = 6'd33;
  localparam logic [5:0] K_COLON   = 6'd34;
  localparam logic [5:0] K_EOF     = 6'd35;
  localparam logic [5:0] K_NEWLINE = 6'd36;
  localparam logic [5:0] K_INDENT  = 6'd37;
  localparam logic [5:0] K_DEDENT  = 6'd38;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_BAD_CHAR  = 3'd1;
  localparam logic [2:0] E_TAB       = 3'd2;
  localparam logic [2:0] E_FIRST_IND = 3'd3;
  localparam logic [2:0] E_MISALIGN  = 3'd4;
  localparam logic [2:0] E_STR_NL    = 3'd5;
  localparam logic [2:0] E_BANG      = 3'd6;
  localparam logic [2:0] E_OVERFLOW  = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBR    = 8'h5D;

  // keyword bytes, first byte in the low octet
  localparam logic [47:0] KW_PAT [KW_COUNT] = '{
    48'h000000006669, 48'h000065736c65, 48'h000066696c65, 48'h00656c696877,
    48'h000000666564, 48'h6e7275746572, 48'h000000646e61, 48'h00000000726f,
    48'h000000746f6e, 48'h000000746e69, 48'h0000006d756e, 48'h000000727473
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd6, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3
  };

  typedef enum logic [7:0] {
    M_LINE    = 8'b0000_0001,
    M_MID     = 8'b0000_0010,
    M_NUM1    = 8'b0000_0100,
    M_NUM2    = 8'b0000_1000,
    M_ID      = 8'b0001_0000,
    M_STR     = 8'b0010_0000,
    M_OP      = 8'b0100_0000,
    M_COMMENT = 8'b1000_0000
  } lex_mode_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXAM = 4'b0010,
    S_POP  = 4'b0100,
    S_FIN  = 4'b1000
  } ctl_state_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [11:0] len;
    logic [15:0] line;
    logic [4:0]  dcnt;
    logic [2:0]  err;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } stk_op_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  function automatic logic [5:0] keyword_kind(input logic [47:0] win,
                                              input logic [11:0] len);
    logic [5:0] kind;
    kind = K_ID;
    for (int i = 0; i < KW_COUNT; i++) begin
      if ((len == {9'd0, KW_LEN[i]}) && (win == KW_PAT[i])) begin
        kind = K_IF + 6'(i);
      end
    end
    return kind;
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                  input logic [11:0] len, input logic [15:0] line,
                                  input logic [4:0] dcnt, input logic [2:0] err);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.dcnt  = dcnt;
    t.err   = err;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

>>> rtl/ial_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation stack cell
// Holds one indentation width; shifts towards the top or the bottom.
// ----------------------------------------------------------------------------
module ial_cell #(
  parameter int INDENT_BITS = ial_pkg::INDENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ial_pkg::stk_op_t       op,
  input  logic [INDENT_BITS-1:0] from_above,
  input  logic [INDENT_BITS-1:0] from_below,
  output logic [INDENT_BITS-1:0] val
);

  logic [INDENT_BITS-1:0] val_r;
  logic [INDENT_BITS-1:0] val_nxt;

  always_comb begin
    priority if (op.clr) begin
      val_nxt = '0;
    end else if (op.push) begin
      val_nxt = from_above;
    end else if (op.pop) begin
      val_nxt = from_below;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

>>> rtl/ial_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation stack
// Row of cells, top of stack in cell 0, with the level counter.
// ----------------------------------------------------------------------------
module ial_stack #(
  parameter int STACK_DEPTH = ial_pkg::STACK_DEPTH_DEF,
  parameter int INDENT_BITS = ial_pkg::INDENT_BITS_DEF,
  localparam int LVL_W      = $clog2(STACK_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ial_pkg::stk_op_t       op,
  input  logic [INDENT_BITS-1:0] push_val,
  output logic [INDENT_BITS-1:0] top,
  output logic [LVL_W-1:0]       level
);

  logic [INDENT_BITS-1:0] vals [STACK_DEPTH];
  logic [LVL_W-1:0]       level_r;
  logic [LVL_W-1:0]       level_nxt;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [INDENT_BITS-1:0] above;
    logic [INDENT_BITS-1:0] below;
    if (i == 0) begin : g_head
      assign above = push_val;
    end else begin : g_body
      assign above = vals[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_inner
      assign below = vals[i+1];
    end
    ial_cell #(.INDENT_BITS(INDENT_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .val        (vals[i])
    );
  end

  always_comb begin
    priority if (op.clr) begin
      level_nxt = '0;
    end else if (op.push) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (op.pop) begin
      level_nxt = level_r - LVL_W'(1);
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  assign top   = vals[0];
  assign level = level_r;

endmodule

>>> rtl/ial_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token output queue
// Small queue between the lexer core and the result channel.
// ----------------------------------------------------------------------------
module ial_fifo #(
  parameter int DEPTH  = ial_pkg::OUT_FIFO_DEPTH,
  localparam int PW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ial_pkg::tok_t wr_data,
  output logic          rd_valid,
  output ial_pkg::tok_t rd_data,
  input  logic          rd_stall,
  output logic [CW-1:0] count
);

  ial_pkg::tok_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          rd_en;

  assign rd_valid = (count_r != '0);
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem_r[rd_ptr_r];
  assign count    = count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule

>>> rtl/indent_aware_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation-aware lexer
// One source byte per transfer in, zero to two tokens per byte out.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_ch               | byte in
//  out     | out_valid, out_stall, out_token_kind .. | token out
//
//  A byte is accepted and then examined, and examined again when it needs a
//  second look; a line start that is not deeper adds a stack compare and a pop
//  step per level popped, and a byte that gives two tokens adds a hand-off.
//  Reset is synchronous, active low; it empties the stack and clears errors.
//  Tokens wait in a four-entry queue; a byte is taken only with two free.
//  After an error token, bytes are counted and give nothing until reset.
// ----------------------------------------------------------------------------
module indent_aware_lexer_unit #(
  parameter int STACK_DEPTH   = ial_pkg::STACK_DEPTH_DEF,
  parameter int POSITION_BITS = ial_pkg::POSITION_BITS_DEF,
  parameter int INDENT_BITS   = ial_pkg::INDENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_text_start,
  output logic [11:0] out_text_len,
  output logic [15:0] out_line_no,
  output logic [4:0]  out_dedent_count,
  output logic [2:0]  out_error_code,
  output logic        out_last
);

  localparam int LVL_W = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(ial_pkg::OUT_FIFO_DEPTH + 1);

  ial_pkg::ctl_state_t state_r, state_nxt;
  ial_pkg::lex_mode_t  mode_r, mode_nxt;
  logic                     pass_r, pass_nxt;
  logic [7:0]               ch_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] spos_r;
  logic [5:0]               pend_r, pend_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt;
  logic [11:0]              len_r, len_nxt, len_inc;
  logic [47:0]              kw_r, kw_nxt;
  logic [INDENT_BITS-1:0]   space_r, space_nxt;
  logic                     first_r, first_nxt;
  logic [15:0]              line_r, line_nxt;
  logic                     err_r, err_nxt;
  logic [LVL_W-1:0]         n_r, n_nxt;
  ial_pkg::tok_t            tokq_r, tokq_nxt;
  logic                     tokq_v_r, tokq_v_nxt;

  ial_pkg::tok_t            nt;
  ial_pkg::tok_t            wr_tok;
  logic                     nt_v, again, go_pop, fin, wr_en, in_acc;
  ial_pkg::stk_op_t         stk_op;
  logic [INDENT_BITS-1:0]   top_w;
  logic [LVL_W-1:0]         level_w;
  logic [CW-1:0]            fifo_cnt;
  ial_pkg::tok_t            rd_tok;
  logic [31:0]              pos_ext, begin_ext, n_ext, lvl_ext;
  logic [15:0]              pos16, begin16;
  logic [5:0]               kw_kind;

  assign pos_ext   = 32'(pos_r);
  assign begin_ext = 32'(begin_r);
  assign n_ext     = 32'(n_r);
  assign lvl_ext   = 32'(level_w);
  assign pos16     = pos_ext[15:0];
  assign begin16   = begin_ext[15:0];
  assign len_inc   = (len_r == 12'hFFF) ? len_r : len_r + 12'd1;
  assign kw_kind   = (len_r > 12'd6) ? ial_pkg::K_ID : ial_pkg::keyword_kind(kw_r, len_r);

  assign in_stall = !((state_r == ial_pkg::S_IDLE) &&
                      (fifo_cnt <= CW'(ial_pkg::OUT_FIFO_DEPTH - 2)));
  assign in_acc   = in_valid && !in_stall;

  ial_stack #(.STACK_DEPTH(STACK_DEPTH), .INDENT_BITS(INDENT_BITS)) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (stk_op),
    .push_val (space_r),
    .top      (top_w),
    .level    (level_w)
  );

  // examine the held byte in the current mode, or pop and compare the stack
  always_comb begin
    nt        = ial_pkg::mk_tok(ial_pkg::K_ERROR, pos16, 12'd0, line_r, 5'd0,
                                ial_pkg::E_NONE);
    nt_v      = 1'b0;
    again     = 1'b0;
    go_pop    = 1'b0;
    stk_op    = '0;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    begin_nxt = begin_r;
    len_nxt   = len_r;
    kw_nxt    = kw_r;
    space_nxt = space_r;
    line_nxt  = line_r;
    err_nxt   = err_r;
    n_nxt     = n_r;

    if (state_r == ial_pkg::S_EXAM) begin
      unique case (mode_r)
        ial_pkg::M_LINE: begin
          if (ch_r == ial_pkg::CH_SPACE) begin
            if (space_r != '1) begin
              space_nxt = space_r + INDENT_BITS'(1);
            end
          end else begin
            mode_nxt = ial_pkg::M_MID;
            priority if ((ch_r == ial_pkg::CH_HASH) || (ch_r == ial_pkg::CH_LF) ||
                         (ch_r == ial_pkg::CH_CR)) begin
              again = 1'b1;
            end else if (ch_r == ial_pkg::CH_TAB) begin
              nt_v = 1'b1;
              nt.err = ial_pkg::E_TAB;
              err_nxt = 1'b1;
            end else if (first_r && (space_r != '0)) begin
              nt_v = 1'b1;
              nt.err = ial_pkg::E_FIRST_IND;
              err_nxt = 1'b1;
            end else if (space_r > top_w) begin
              if (level_w == LVL_W'(STACK_DEPTH - 1)) begin
                nt_v = 1'b1;
                nt.err = ial_pkg::E_OVERFLOW;
                err_nxt = 1'b1;
              end else begin
                stk_op.push = 1'b1;
                nt_v = 1'b1;
                nt.kind = ial_pkg::K_INDENT;
                again = 1'b1;
              end
            end else begin
              go_pop = 1'b1;
              n_nxt  = '0;
            end
          end
        end
        ial_pkg::M_MID: begin
          priority if (ial_pkg::is_digit(ch_r)) begin
            mode_nxt = ial_pkg::M_NUM1;
            pend_nxt = ial_pkg::K_NUMBER;
            begin_nxt = pos_r;
            len_nxt = 12'd1;
          end else if (ial_pkg::is_alpha(ch_r)) begin
            mode_nxt = ial_pkg::M_ID;
            pend_nxt = ial_pkg::K_ID;
            begin_nxt = pos_r;
            len_nxt = 12'd1;
            kw_nxt = {40'd0, ch_r};
          end else begin
            case (ch_r)
              ial_pkg::CH_SPACE, ial_pkg::CH_TAB, ial_pkg::CH_CR,
              ial_pkg::CH_VT, ial_pkg::CH_FF: begin
              end
              ial_pkg::CH_GT, ial_pkg::CH_LT, ial_pkg::CH_MINUS,
              ial_pkg::CH_EQ, ial_pkg::CH_BANG, ial_pkg::CH_QUOTE: begin
                mode_nxt = (ch_r == ial_pkg::CH_QUOTE) ? ial_pkg::M_STR : ial_pkg::M_OP;
                begin_nxt = pos_r;
                len_nxt = 12'd1;
                unique case (ch_r)
                  ial_pkg::CH_GT:    pend_nxt = ial_pkg::K_GT;
                  ial_pkg::CH_LT:    pend_nxt = ial_pkg::K_LT;
                  ial_pkg::CH_MINUS: pend_nxt = ial_pkg::K_MINUS;
                  ial_pkg::CH_EQ:    pend_nxt = ial_pkg::K_ASSIGN;
                  ial_pkg::CH_BANG:  pend_nxt = ial_pkg::K_NEQ;
                  default:           pend_nxt = ial_pkg::K_STRING;
                endcase
              end
              ial_pkg::CH_HASH: mode_nxt = ial_pkg::M_COMMENT;
              ial_pkg::CH_PLUS: begin nt_v = 1'b1; nt.kind = ial_pkg::K_PLUS; end
              ial_pkg::CH_STAR: begin nt_v = 1'b1; nt.kind = ial_pkg::K_MUL; end
              ial_pkg::CH_SLASH: begin nt_v = 1'b1; nt.kind = ial_pkg::K_DIV; end
              ial_pkg::CH_PCT: begin nt_v = 1'b1; nt.kind = ial_pkg::K_MOD; end
              ial_pkg::CH_LPAR: begin nt_v = 1'b1; nt.kind = ial_pkg::K_LPAR; end
              ial_pkg::CH_RPAR: begin nt_v = 1'b1; nt.kind = ial_pkg::K_RPAR; end
              ial_pkg::CH_LBR: begin nt_v = 1'b1; nt.kind = ial_pkg::K_LBR; end
              ial_pkg::CH_RBR: begin nt_v = 1'b1; nt.kind = ial_pkg::K_RBR; end
              ial_pkg::CH_COMMA: begin nt_v = 1'b1; nt.kind = ial_pkg::K_COMMA; end
              ial_pkg::CH_COLON: begin nt_v = 1'b1; nt.kind = ial_pkg::K_COLON; end
              ial_pkg::CH_NUL: begin
                stk_op.clr = 1'b1;
                nt_v = 1'b1;
                nt.kind = ial_pkg::K_EOF;
                nt.dcnt = lvl_ext[4:0];
              end
              ial_pkg::CH_LF: begin
                nt_v = 1'b1;
                nt.kind = ial_pkg::K_NEWLINE;
                line_nxt = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;
                mode_nxt = ial_pkg::M_LINE;
                space_nxt = '0;
              end
              default: begin
                nt_v = 1'b1;
                nt.err = ial_pkg::E_BAD_CHAR;
                err_nxt = 1'b1;
              end
            endcase
          end
        end
        ial_pkg::M_NUM1, ial_pkg::M_NUM2: begin
          if (ial_pkg::is_digit(ch_r) ||
              ((ch_r == ial_pkg::CH_BSLASH) && (mode_r == ial_pkg::M_NUM1))) begin
            if (ch_r == ial_pkg::CH_BSLASH) begin
              mode_nxt = ial_pkg::M_NUM2;
            end
            len_nxt = len_inc;
          end else begin
            nt_v = 1'b1;
            nt = ial_pkg::mk_tok(ial_pkg::K_NUMBER, begin16, len_r, line_r, 5'd0,
                                 ial_pkg::E_NONE);
            mode_nxt = ial_pkg::M_MID;
            again = 1'b1;
          end
        end
        ial_pkg::M_ID: begin
          if (ial_pkg::is_alpha(ch_r) || ial_pkg::is_digit(ch_r)) begin
            if (len_r < 12'd6) begin
              kw_nxt[len_r[2:0]*8 +: 8] = ch_r;
            end
            len_nxt = len_inc;
          end else begin
            nt_v = 1'b1;
            nt = ial_pkg::mk_tok(kw_kind, begin16,
                                 (kw_kind == ial_pkg::K_ID) ? len_r : 12'd0, line_r,
                                 5'd0, ial_pkg::E_NONE);
            mode_nxt = ial_pkg::M_MID;
            again = 1'b1;
          end
        end
        ial_pkg::M_STR: begin
          if (ch_r == ial_pkg::CH_LF) begin
            nt_v = 1'b1;
            nt.err = ial_pkg::E_STR_NL;
            err_nxt = 1'b1;
          end else begin
            len_nxt = len_inc;
            if (ch_r == ial_pkg::CH_QUOTE) begin
              nt_v = 1'b1;
              nt = ial_pkg::mk_tok(ial_pkg::K_STRING, begin16, len_inc, line_r, 5'd0,
                                   ial_pkg::E_NONE);
              mode_nxt = ial_pkg::M_MID;
            end
          end
        end
        ial_pkg::M_OP: begin
          mode_nxt = ial_pkg::M_MID;
          nt_v = 1'b1;
          nt.start = begin16;
          priority if ((pend_r == ial_pkg::K_MINUS) && (ch_r == ial_pkg::CH_GT)) begin
            nt.kind = ial_pkg::K_ARROW;
          end else if ((pend_r != ial_pkg::K_MINUS) && (ch_r == ial_pkg::CH_EQ)) begin
            priority if (pend_r == ial_pkg::K_GT) begin
              nt.kind = ial_pkg::K_GE;
            end else if (pend_r == ial_pkg::K_LT) begin
              nt.kind = ial_pkg::K_LE;
            end else if (pend_r == ial_pkg::K_ASSIGN) begin
              nt.kind = ial_pkg::K_EQ;
            end else begin
              nt.kind = ial_pkg::K_NEQ;
            end
          end else if (pend_r == ial_pkg::K_NEQ) begin
            // the byte after a lone bang goes with the error
            nt.start = pos16;
            nt.err = ial_pkg::E_BANG;
            err_nxt = 1'b1;
          end else begin
            nt.kind = pend_r;
            again = 1'b1;
          end
        end
        ial_pkg::M_COMMENT: begin
          if (ch_r == ial_pkg::CH_LF) begin
            nt_v = 1'b1;
            nt.kind = ial_pkg::K_NEWLINE;
            line_nxt = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;
            mode_nxt = ial_pkg::M_LINE;
            space_nxt = '0;
          end else if (ch_r == ial_pkg::CH_NUL) begin
            stk_op.clr = 1'b1;
            nt_v = 1'b1;
            nt.kind = ial_pkg::K_EOF;
            nt.dcnt = lvl_ext[4:0];
            mode_nxt = ial_pkg::M_MID;
          end
        end
        default: begin
          mode_nxt = ial_pkg::M_MID;
          again = 1'b1;
        end
      endcase
    end else if (state_r == ial_pkg::S_POP) begin
      // pop one level a cycle while the top is deeper than the line
      priority if ((level_w != '0) && (top_w > space_r)) begin
        stk_op.pop = 1'b1;
        n_nxt = n_r + LVL_W'(1);
      end else if (top_w < space_r) begin
        nt_v = 1'b1;
        nt.err = ial_pkg::E_MISALIGN;
        err_nxt = 1'b1;
      end else if (n_r != '0) begin
        nt_v = 1'b1;
        nt.kind = ial_pkg::K_DEDENT;
        nt.dcnt = n_ext[4:0];
      end else begin
      end
    end

    first_nxt = first_r;
    if (nt_v && (nt.kind != ial_pkg::K_NEWLINE) && (nt.kind != ial_pkg::K_DEDENT)) begin
      first_nxt = 1'b0;
    end
  end

  // sequencing and token hand-off
  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    fin        = 1'b0;
    wr_en      = 1'b0;
    wr_tok     = tokq_r;
    tokq_nxt   = tokq_r;
    tokq_v_nxt = tokq_v_r;

    unique case (state_r)
      ial_pkg::S_IDLE: begin
        if (in_acc && !err_r) begin
          state_nxt = ial_pkg::S_EXAM;
          pass_nxt  = 1'b0;
        end
      end
      ial_pkg::S_EXAM: begin
        if (go_pop) begin
          state_nxt = ial_pkg::S_POP;
        end else if (again && !pass_r) begin
          pass_nxt = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      ial_pkg::S_POP: begin
        if (!stk_op.pop) begin
          if (err_nxt) begin
            fin = 1'b1;
          end else begin
            state_nxt = ial_pkg::S_EXAM;
            pass_nxt  = 1'b1;
          end
        end
      end
      ial_pkg::S_FIN: begin
        wr_en      = 1'b1;
        wr_tok     = tokq_r;
        wr_tok.last = 1'b1;
        tokq_v_nxt = 1'b0;
        state_nxt  = ial_pkg::S_IDLE;
      end
      default: state_nxt = ial_pkg::S_IDLE;
    endcase

    if ((state_r == ial_pkg::S_EXAM) || (state_r == ial_pkg::S_POP)) begin
      if (fin) begin
        state_nxt = ial_pkg::S_IDLE;
      end
      priority if (nt_v && tokq_v_r) begin
        // hand the older token on, hold the new one
        wr_en    = 1'b1;
        wr_tok   = tokq_r;
        tokq_nxt = nt;
        if (fin) begin
          state_nxt = ial_pkg::S_FIN;
        end
      end else if (nt_v) begin
        if (fin) begin
          wr_en       = 1'b1;
          wr_tok      = nt;
          wr_tok.last = 1'b1;
        end else begin
          tokq_nxt   = nt;
          tokq_v_nxt = 1'b1;
        end
      end else if (fin && tokq_v_r) begin
        wr_en       = 1'b1;
        wr_tok      = tokq_r;
        wr_tok.last = 1'b1;
        tokq_v_nxt  = 1'b0;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ial_pkg::S_IDLE;
      mode_r   <= ial_pkg::M_LINE;
      pass_r   <= 1'b0;
      spos_r   <= '0;
      pend_r   <= '0;
      begin_r  <= '0;
      len_r    <= '0;
      kw_r     <= '0;
      space_r  <= '0;
      first_r  <= 1'b1;
      line_r   <= 16'd1;
      err_r    <= 1'b0;
      n_r      <= '0;
      tokq_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      pass_r   <= pass_nxt;
      pend_r   <= pend_nxt;
      begin_r  <= begin_nxt;
      len_r    <= len_nxt;
      kw_r     <= kw_nxt;
      space_r  <= space_nxt;
      first_r  <= first_nxt;
      line_r   <= line_nxt;
      err_r    <= err_nxt;
      n_r      <= n_nxt;
      tokq_v_r <= tokq_v_nxt;
      if (in_acc) begin
        spos_r <= spos_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    tokq_r <= tokq_nxt;
    if (in_acc) begin
      ch_r  <= in_ch;
      pos_r <= spos_r;
    end
  end

  ial_fifo #(.DEPTH(ial_pkg::OUT_FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_data  (wr_tok),
    .rd_valid (out_valid),
    .rd_data  (rd_tok),
    .rd_stall (out_stall),
    .count    (fifo_cnt)
  );

  assign out_token_kind   = rd_tok.kind;
  assign out_text_start   = rd_tok.start;
  assign out_text_len     = rd_tok.len;
  assign out_line_no      = rd_tok.line;
  assign out_dedent_count = rd_tok.dcnt;
  assign out_error_code   = rd_tok.err;
  assign out_last         = rd_tok.last;

endmodule

>>> rtl/ial_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation lexer port checker
// Watches the token channel of the lexer top level.
// ----------------------------------------------------------------------------
`include "indent_aware_lexer_unit_macros.svh"

module ial_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_ch,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_token_kind,
  input logic [15:0] out_text_start,
  input logic [11:0] out_text_len,
  input logic [15:0] out_line_no,
  input logic [4:0]  out_dedent_count,
  input logic [2:0]  out_error_code,
  input logic        out_last
);

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_ch) ^ (^out_text_start) ^ (^out_line_no);

  `IAL_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(out_token_kind) && $stable(out_text_len) && $stable(out_last),
    "stalled token changed")
  `IAL_ASSERT_NOW(a_err_kind, out_valid && (out_token_kind != ial_pkg::K_ERROR),
    out_error_code == ial_pkg::E_NONE, "error code on a non-error token")
  `IAL_ASSERT_NOW(a_dcnt_kind, out_valid && (out_dedent_count != 5'd0),
    (out_token_kind == ial_pkg::K_DEDENT) || (out_token_kind == ial_pkg::K_EOF),
    "pop count on a token that pops nothing")
  `IAL_ASSERT_NOW(a_len_kind, out_valid && (out_text_len != 12'd0),
    (out_token_kind == ial_pkg::K_ID) || (out_token_kind == ial_pkg::K_NUMBER) ||
    (out_token_kind == ial_pkg::K_STRING), "text length on a token without text")

endmodule

bind indent_aware_lexer_unit ial_checker u_ial_checker (.*);

>>> verif/indent_aware_lexer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indentation lexer testbench
// Feeds source bytes through a clocked driver: a directed program, random
// well-formed programs and one closing error. A token predictor built into the
// bench works out the expected tokens for each accepted byte. A clocked monitor
// compares each token that leaves the block with the oldest expected token.
// ----------------------------------------------------------------------------
module indent_aware_lexer_unit_tb;

  localparam int DEPTH     = ial_pkg::STACK_DEPTH_DEF;
  localparam int MAX_CYC   = 400000;
  localparam int HOLD_AT   = 200;
  localparam int HOLD_LEN  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_token_kind;
  logic [15:0] out_text_start;
  logic [11:0] out_text_len;
  logic [15:0] out_line_no;
  logic [4:0]  out_dedent_count;
  logic [2:0]  out_error_code;
  logic        out_last;

  indent_aware_lexer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_text_start(out_text_start),
    .out_text_len(out_text_len), .out_line_no(out_line_no),
    .out_dedent_count(out_dedent_count), .out_error_code(out_error_code),
    .out_last(out_last)
  );

  // source bytes waiting for the driver, tokens waiting for the monitor
  logic [7:0]    src_bytes [$];
  ial_pkg::tok_t token_fifo [$];
  ial_pkg::tok_t step_toks [$];

  int bytes_taken;
  int mismatches;
  int cycles;
  int hold_cnt;
  bit hold_done;
  bit in_fire;

  // predictor state
  ial_pkg::lex_mode_t lx_mode;
  logic [7:0]  lx_stack [DEPTH];
  int          lx_level;
  int          lx_spaces;
  bit          lx_first;
  int          lx_line;
  logic [15:0] lx_pos;
  logic [15:0] lx_begin;
  logic [5:0]  lx_pend;
  logic [47:0] lx_window;
  bit          lx_err;
  int          lx_len;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void put_tok(logic [5:0] kind, logic [15:0] start, int len,
                                  int dcnt, logic [2:0] err);
    ial_pkg::tok_t t;
    if (step_toks.size() >= 2) return;
    t.kind  = kind;
    t.start = start;
    t.len   = len[11:0];
    t.line  = lx_line[15:0];
    t.dcnt  = dcnt[4:0];
    t.err   = err;
    t.last  = 1'b0;
    step_toks.push_back(t);
    if (kind != ial_pkg::K_NEWLINE && kind != ial_pkg::K_DEDENT) lx_first = 1'b0;
  endfunction

  function automatic void flag_error(logic [2:0] code, logic [15:0] pos);
    put_tok(ial_pkg::K_ERROR, pos, 0, 0, code);
    lx_err = 1'b1;
  endfunction

  function automatic int pop_levels(int target);
    int n;
    n = 0;
    while (lx_level > 0 && lx_level < DEPTH && int'(lx_stack[lx_level]) > target) begin
      lx_level--;
      n++;
    end
    return n;
  endfunction

  function automatic void open_token(ial_pkg::lex_mode_t m, logic [5:0] kind,
                                     logic [15:0] pos);
    lx_mode  = m;
    lx_pend  = kind;
    lx_begin = pos;
    lx_len   = 1;
  endfunction

  function automatic void end_line(logic [15:0] pos);
    put_tok(ial_pkg::K_NEWLINE, pos, 0, 0, ial_pkg::E_NONE);
    if (lx_line < 65535) lx_line++;
    lx_mode   = ial_pkg::M_LINE;
    lx_spaces = 0;
  endfunction

  function automatic void close_input(logic [15:0] pos);
    int n;
    n = pop_levels(0);
    lx_level = 0;
    put_tok(ial_pkg::K_EOF, pos, 0, n, ial_pkg::E_NONE);
  endfunction

  function automatic logic [5:0] word_kind();
    logic [5:0] k;
    k = ial_pkg::K_ID;
    if (lx_len <= 6)
      for (int i = 0; i < ial_pkg::KW_COUNT; i++)
        if (lx_len == int'(ial_pkg::KW_LEN[i]) && lx_window == ial_pkg::KW_PAT[i])
          k = ial_pkg::K_IF + 6'(i);
    return k;
  endfunction

  function automatic bit is_digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // returns 1 when the byte has to be looked at again in mid-line mode
  function automatic bit examine_byte(logic [7:0] c, logic [15:0] pos);
    int n;
    logic [5:0] k;
    case (lx_mode)
      ial_pkg::M_LINE: begin
        if (c == ial_pkg::CH_SPACE) begin
          if (lx_spaces < (1 << ial_pkg::INDENT_BITS_DEF) - 1) lx_spaces++;
          return 1'b0;
        end
        lx_mode = ial_pkg::M_MID;
        if (c == ial_pkg::CH_HASH || c == ial_pkg::CH_LF || c == ial_pkg::CH_CR)
          return 1'b1;
        if (c == ial_pkg::CH_TAB) begin
          flag_error(ial_pkg::E_TAB, pos);
          return 1'b0;
        end
        if (lx_first && lx_spaces > 0) begin
          flag_error(ial_pkg::E_FIRST_IND, pos);
          return 1'b0;
        end
        if (lx_level >= DEPTH) lx_level = 0;
        if (lx_spaces > int'(lx_stack[lx_level])) begin
          if (lx_level + 1 >= DEPTH) begin
            flag_error(ial_pkg::E_OVERFLOW, pos);
            return 1'b0;
          end
          lx_level++;
          lx_stack[lx_level] = lx_spaces[7:0];
          put_tok(ial_pkg::K_INDENT, pos, 0, 0, ial_pkg::E_NONE);
          return 1'b1;
        end
        n = pop_levels(lx_spaces);
        if (int'(lx_stack[lx_level]) < lx_spaces) begin
          flag_error(ial_pkg::E_MISALIGN, pos);
          return 1'b0;
        end
        if (n > 0) put_tok(ial_pkg::K_DEDENT, pos, 0, n, ial_pkg::E_NONE);
        return 1'b1;
      end
      ial_pkg::M_MID: begin
        if (is_digit_c(c)) begin
          open_token(ial_pkg::M_NUM1, ial_pkg::K_NUMBER, pos);
          return 1'b0;
        end
        if (is_alpha_c(c)) begin
          open_token(ial_pkg::M_ID, ial_pkg::K_ID, pos);
          lx_window = {40'd0, c};
          return 1'b0;
        end
        case (c)
          ial_pkg::CH_SPACE, ial_pkg::CH_TAB, ial_pkg::CH_CR, ial_pkg::CH_VT,
          ial_pkg::CH_FF: ;
          ial_pkg::CH_GT:    open_token(ial_pkg::M_OP, ial_pkg::K_GT, pos);
          ial_pkg::CH_LT:    open_token(ial_pkg::M_OP, ial_pkg::K_LT, pos);
          ial_pkg::CH_MINUS: open_token(ial_pkg::M_OP, ial_pkg::K_MINUS, pos);
          ial_pkg::CH_EQ:    open_token(ial_pkg::M_OP, ial_pkg::K_ASSIGN, pos);
          ial_pkg::CH_BANG:  open_token(ial_pkg::M_OP, ial_pkg::K_NEQ, pos);
          ial_pkg::CH_QUOTE: open_token(ial_pkg::M_STR, ial_pkg::K_STRING, pos);
          ial_pkg::CH_HASH:  lx_mode = ial_pkg::M_COMMENT;
          ial_pkg::CH_PLUS:  put_tok(ial_pkg::K_PLUS, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_STAR:  put_tok(ial_pkg::K_MUL, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_SLASH: put_tok(ial_pkg::K_DIV, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_PCT:   put_tok(ial_pkg::K_MOD, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_LPAR:  put_tok(ial_pkg::K_LPAR, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_RPAR:  put_tok(ial_pkg::K_RPAR, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_LBR:   put_tok(ial_pkg::K_LBR, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_RBR:   put_tok(ial_pkg::K_RBR, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_COMMA: put_tok(ial_pkg::K_COMMA, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_COLON: put_tok(ial_pkg::K_COLON, pos, 0, 0, ial_pkg::E_NONE);
          ial_pkg::CH_NUL:   close_input(pos);
          ial_pkg::CH_LF:    end_line(pos);
          default:           flag_error(ial_pkg::E_BAD_CHAR, pos);
        endcase
        return 1'b0;
      end
      ial_pkg::M_NUM1, ial_pkg::M_NUM2: begin
        if (is_digit_c(c) || (c == ial_pkg::CH_BSLASH && lx_mode == ial_pkg::M_NUM1)) begin
          if (c == ial_pkg::CH_BSLASH) lx_mode = ial_pkg::M_NUM2;
          if (lx_len < 4095) lx_len++;
          return 1'b0;
        end
        put_tok(ial_pkg::K_NUMBER, lx_begin, lx_len, 0, ial_pkg::E_NONE);
        lx_mode = ial_pkg::M_MID;
        return 1'b1;
      end
      ial_pkg::M_ID: begin
        if (is_alpha_c(c) || is_digit_c(c)) begin
          if (lx_len < 6) lx_window[8*lx_len +: 8] = c;
          if (lx_len < 4095) lx_len++;
          return 1'b0;
        end
        k = word_kind();
        put_tok(k, lx_begin, (k == ial_pkg::K_ID) ? lx_len : 0, 0, ial_pkg::E_NONE);
        lx_mode = ial_pkg::M_MID;
        return 1'b1;
      end
      ial_pkg::M_STR: begin
        if (c == ial_pkg::CH_LF) begin
          flag_error(ial_pkg::E_STR_NL, pos);
          return 1'b0;
        end
        if (lx_len < 4095) lx_len++;
        if (c == ial_pkg::CH_QUOTE) begin
          put_tok(ial_pkg::K_STRING, lx_begin, lx_len, 0, ial_pkg::E_NONE);
          lx_mode = ial_pkg::M_MID;
        end
        return 1'b0;
      end
      ial_pkg::M_OP: begin
        lx_mode = ial_pkg::M_MID;
        if (lx_pend == ial_pkg::K_MINUS) begin
          if (c == ial_pkg::CH_GT) begin
            put_tok(ial_pkg::K_ARROW, lx_begin, 0, 0, ial_pkg::E_NONE);
            return 1'b0;
          end
        end else if (c == ial_pkg::CH_EQ) begin
          k = (lx_pend == ial_pkg::K_GT) ? ial_pkg::K_GE :
              (lx_pend == ial_pkg::K_LT) ? ial_pkg::K_LE :
              (lx_pend == ial_pkg::K_ASSIGN) ? ial_pkg::K_EQ : ial_pkg::K_NEQ;
          put_tok(k, lx_begin, 0, 0, ial_pkg::E_NONE);
          return 1'b0;
        end
        if (lx_pend == ial_pkg::K_NEQ) begin
          flag_error(ial_pkg::E_BANG, pos);
          return 1'b0;
        end
        put_tok(lx_pend, lx_begin, 0, 0, ial_pkg::E_NONE);
        return 1'b1;
      end
      ial_pkg::M_COMMENT: begin
        if (c == ial_pkg::CH_LF) end_line(pos);
        else if (c == ial_pkg::CH_NUL) begin
          close_input(pos);
          lx_mode = ial_pkg::M_MID;
        end
        return 1'b0;
      end
      default: begin
        lx_mode = ial_pkg::M_MID;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] c);
    logic [15:0] pos;
    ial_pkg::tok_t t;
    pos = lx_pos;
    lx_pos++;
    step_toks.delete();
    if (lx_err) return;
    for (int p = 0; p < 2; p++)
      if (!examine_byte(c, pos) || lx_err) break;
    foreach (step_toks[i]) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      token_fifo.push_back(t);
    end
  endfunction

  // ---------------- source generation ----------------
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) src_bytes.push_back(ial_pkg::CH_SPACE);
  endfunction

  function automatic void add_token(ref bit no_glue);
    string kw [12] = '{"if", "else", "elif", "while", "def", "return",
                       "and", "or", "not", "int", "num", "str"};
    string ops [19] = '{">", ">=", "<", "<=", "-", "->", "=", "==", "!=", "+",
                        "*", "/", "%", "(", ")", "[", "]", ",", ":"};
    logic [7:0] b;
    int n;
    no_glue = 1'b0;
    case ($urandom_range(0, 9))
      0, 1: add_text(kw[$urandom_range(0, 11)]);
      2, 3: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, (i == 0) ? 2 : 3))
            0: b = 8'($urandom_range("a", "z"));
            1: b = 8'($urandom_range("A", "Z"));
            2: b = "_";
            default: b = 8'($urandom_range("0", "9"));
          endcase
          src_bytes.push_back(b);
        end
      end
      4: begin
        repeat ($urandom_range(1, 4)) src_bytes.push_back(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 1)) begin
          src_bytes.push_back(ial_pkg::CH_BSLASH);
          repeat ($urandom_range(0, 3)) src_bytes.push_back(8'($urandom_range("0", "9")));
        end
        no_glue = 1'b1;
      end
      5: begin
        src_bytes.push_back(ial_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(0, 255));
          if (b == ial_pkg::CH_QUOTE || b == ial_pkg::CH_LF) b = 8'($urandom_range(128, 255));
          src_bytes.push_back(b);
        end
        src_bytes.push_back(ial_pkg::CH_QUOTE);
      end
      6: case ($urandom_range(0, 3))
           0: src_bytes.push_back(ial_pkg::CH_TAB);
           1: src_bytes.push_back(ial_pkg::CH_CR);
           2: src_bytes.push_back(ial_pkg::CH_VT);
           default: src_bytes.push_back(ial_pkg::CH_FF);
         endcase
      default: add_text(ops[$urandom_range(0, 18)]);
    endcase
  endfunction

  function automatic void add_line(ref int levels [$]);
    int sel;
    int cols;
    bit no_glue;
    if ($urandom_range(0, 9) == 0) begin
      // blank or comment-only line, indentation ignored
      add_spaces($urandom_range(0, 9));
      if ($urandom_range(0, 1)) begin
        src_bytes.push_back(ial_pkg::CH_HASH);
        repeat ($urandom_range(0, 4)) src_bytes.push_back(8'($urandom_range(1, 255)) | 8'h80);
      end
      src_bytes.push_back(ial_pkg::CH_LF);
      return;
    end
    sel = $urandom_range(0, 2);
    if (sel == 0 && levels.size() < 12 && int'(levels[$]) < 200)
      levels.push_back(levels[$] + $urandom_range(1, 5));
    else if (sel == 1 && levels.size() > 1)
      repeat ($urandom_range(1, levels.size() - 1)) void'(levels.pop_back());
    cols = levels[$];
    add_spaces(cols);
    no_glue = 1'b1;
    repeat ($urandom_range(1, 6)) begin
      if (no_glue || $urandom_range(0, 2) != 0) src_bytes.push_back(ial_pkg::CH_SPACE);
      add_token(no_glue);
    end
    if ($urandom_range(0, 7) == 0) add_text(" # note");
    if ($urandom_range(0, 19) == 0) begin
      src_bytes.push_back(ial_pkg::CH_SPACE);
      src_bytes.push_back(ial_pkg::CH_NUL);
      levels = '{0};
    end
    src_bytes.push_back(ial_pkg::CH_LF);
  endfunction

  function automatic void add_closing_error();
    case ($urandom_range(0, 5))
      0: add_text("\nx $ y\n");
      1: begin
        add_text("\n");
        src_bytes.push_back(ial_pkg::CH_TAB);
        add_text("x\n");
      end
      2: begin
        src_bytes.push_back(ial_pkg::CH_NUL);
        add_text("\nq\n    r\n  s\n");
      end
      3: add_text("\nx = \"ab\nc\n");
      4: add_text("\nx !y\n");
      default: begin
        src_bytes.push_back(ial_pkg::CH_NUL);
        add_text("\n");
        for (int i = 1; i <= DEPTH; i++) begin
          add_spaces(i);
          add_text("v\n");
        end
      end
    endcase
  endfunction

  // ---------------- stimulus ----------------
  initial begin
    int levels [$];
    // keywords, operators, fractions, adjacency, indent, dedent by two, eof
    add_text("if else elif while def return and or not int num str iffy Ab_9\n");
    add_text("x=12\\34+a>=b<=c->d==e!=f-g<h>i*(j)/[k]%l,m:n  # cmt\xff\n");
    add_text("def f1():\n  while z:\n      y = \"a\xc8\x00\"\n   \n  # c\n");
    add_text("q\t\x0b\x0c\r9\\1\\2 = 4\n");
    add_spaces(300);
    src_bytes.push_back(ial_pkg::CH_NUL);
    add_text("\nw\n");
    levels = '{0};
    while (src_bytes.size() < 800) add_line(levels);
    add_closing_error();
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // ---------------- driver ----------------
  function automatic int phase_now();
    return (bytes_taken < 270) ? 0 : (bytes_taken < 540) ? 1 : 2;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch    <= 8'd0;
    end else if (!in_valid || in_fire) begin
      // previous transfer done (or nothing offered): offer the next byte, if any, unless held back at random
      if (src_bytes.size() > 0 &&
          !(phase_now() == 0 && $urandom_range(0, 99) < 32) &&
          !(phase_now() == 1 && $urandom_range(0, 99) < 49)) begin
        in_valid <= 1'b1;
        in_ch    <= src_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so that the token queue fills up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= (phase_now() == 0) ? ($urandom_range(0, 99) < 49) :
                   (phase_now() == 1) ? ($urandom_range(0, 99) < 32) : 1'b0;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    ial_pkg::tok_t got;
    ial_pkg::tok_t want;
    if (!rst_n) begin
      in_fire   = 1'b0;
      lx_mode   = ial_pkg::M_LINE;
      foreach (lx_stack[i]) lx_stack[i] = 8'd0;
      lx_level  = 0;
      lx_spaces = 0;
      lx_first  = 1'b1;
      lx_line   = 1;
      lx_pos    = 16'd0;
      lx_begin  = 16'd0;
      lx_pend   = ial_pkg::K_ERROR;
      lx_window = 48'd0;
      lx_err    = 1'b0;
      lx_len    = 0;
    end else begin
      // the driver moves on only after a transfer seen at this edge
      in_fire = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = '{out_token_kind, out_text_start, out_text_len, out_line_no,
                out_dedent_count, out_error_code, out_last};
        if (token_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected token: kind %0d start %0d len %0d line %0d",
                     got.kind, got.start, got.len, got.line);
        end else begin
          want = token_fifo.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"token mismatch: exp kind %0d start %0d len %0d line %0d ",
                        "dcnt %0d err %0d last %0d / got %0d %0d %0d %0d %0d %0d %0d"},
                       want.kind, want.start, want.len, want.line, want.dcnt,
                       want.err, want.last, got.kind, got.start, got.len, got.line,
                       got.dcnt, got.err, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_tokens(in_ch);
        bytes_taken++;
      end
    end
  end

  // ---------------- end of run ----------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("indent_aware_lexer_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    bytes_taken = 0;
    mismatches  = 0;
    cycles      = 0;
    wait (rst_n);
    wait (src_bytes.size() == 0 && !in_valid);
    wait (token_fifo.size() == 0);
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("indent_aware_lexer_unit_tb OK");
    else
      $display("indent_aware_lexer_unit_tb NOT OK");
    $finish;
  end

endmodule
